/* rtl/tlb_pkg.sv */
// Shared constants, types and state encoding for the TLB page-table translator.
`default_nettype none
package tlb_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_COUNT  = 256;
  localparam int PAGE_BYTES  = 256;
  localparam int FRAME_COUNT = 256;

  localparam int ADDR_W    = 16;
  localparam int OFFSET_W  = $clog2(PAGE_BYTES);
  localparam int PAGE_W    = $clog2(PAGE_COUNT);
  localparam int FRAME_W   = $clog2(FRAME_COUNT);
  localparam int FREE_W    = $clog2(FRAME_COUNT + 1);
  localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);

  // m_tuser bit positions
  localparam int USER_W         = 3;
  localparam int USER_HIT       = 0;
  localparam int USER_FAULT     = 1;
  localparam int USER_EXHAUSTED = 2;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic capture;  // latch address, start page-table read
    logic commit;   // write result, update TLB / page map
  } cmd_t;

  typedef struct packed {
    logic out_free; // output register empty or being drained
  } sts_t;

endpackage
`default_nettype wire

/* rtl/tlb_ctrl.sv */
// Controller state machine: sequences capture and lookup/commit of each address.
`default_nettype none
module tlb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire tlb_pkg::sts_t sts,
  output tlb_pkg::cmd_t      cmd
);

  tlb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tlb_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = tlb_pkg::ST_LOOKUP;
      end
      tlb_pkg::ST_LOOKUP: begin
        if (sts.out_free) state_next = tlb_pkg::ST_IDLE;
      end
      default: state_next = tlb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      tlb_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      tlb_pkg::ST_LOOKUP: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/tlb_datapath.sv */
// Datapath: TLB entries, page-map memory, frame allocator and output register.
`default_nettype none
module tlb_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [tlb_pkg::ADDR_W-1:0]    s_tdata,
  input  wire tlb_pkg::cmd_t                 cmd,
  output tlb_pkg::sts_t                      sts,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [tlb_pkg::ADDR_W-1:0]         m_tdata,
  output logic [tlb_pkg::USER_W-1:0]         m_tuser
);

  logic [tlb_pkg::ADDR_W-1:0]    addr_q;
  logic [tlb_pkg::PAGE_W-1:0]    page;
  logic [tlb_pkg::OFFSET_W-1:0]  offset;
  logic [tlb_pkg::PAGE_W-1:0]    in_page;

  // page map: valid bits in flops, frames in a memory with registered read
  logic [tlb_pkg::PAGE_COUNT-1:0] map_valid;
  logic [tlb_pkg::FRAME_W-1:0]    map_frame [tlb_pkg::PAGE_COUNT];
  logic [tlb_pkg::FRAME_W-1:0]    map_rd;

  logic [tlb_pkg::TLB_ENTRIES-1:0] tlb_valid;
  logic [tlb_pkg::PAGE_W-1:0]      tlb_page  [tlb_pkg::TLB_ENTRIES];
  logic [tlb_pkg::FRAME_W-1:0]     tlb_frame [tlb_pkg::TLB_ENTRIES];
  logic [tlb_pkg::TLB_IDX_W-1:0]   fifo_ptr;
  logic [tlb_pkg::FREE_W-1:0]      next_free;

  logic                          hit, map_hit, fault, exhausted, fill;
  logic [tlb_pkg::FRAME_W-1:0]   hit_frame, frame;
  logic [tlb_pkg::ADDR_W-1:0]    phys;

  assign in_page = s_tdata[tlb_pkg::OFFSET_W +: tlb_pkg::PAGE_W];
  assign page    = addr_q[tlb_pkg::OFFSET_W +: tlb_pkg::PAGE_W];
  assign offset  = addr_q[tlb_pkg::OFFSET_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_q <= s_tdata;
      map_rd <= map_frame[in_page];
    end
    if (cmd.commit && fault) begin
      map_frame[page] <= frame;
    end
  end

  // fully associative compare; lowest matching entry wins
  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int i = tlb_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid[i] && tlb_page[i] == page) begin
        hit       = 1'b1;
        hit_frame = tlb_frame[i];
      end
    end
  end

  always_comb begin
    map_hit   = !hit && map_valid[page];
    fault     = !hit && !map_valid[page] &&
                (next_free != tlb_pkg::FREE_W'(tlb_pkg::FRAME_COUNT));
    exhausted = !hit && !map_valid[page] &&
                (next_free == tlb_pkg::FREE_W'(tlb_pkg::FRAME_COUNT));
    fill      = map_hit || fault;
    if (hit) begin
      frame = hit_frame;
    end else if (map_hit) begin
      frame = map_rd;
    end else begin
      frame = next_free[tlb_pkg::FRAME_W-1:0];
    end
    if (exhausted) begin
      phys = '0;
    end else begin
      phys = tlb_pkg::ADDR_W'({frame, offset});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= '0;
      tlb_valid <= '0;
      fifo_ptr  <= '0;
      next_free <= '0;
    end else if (cmd.commit) begin
      if (fault) begin
        map_valid[page] <= 1'b1;
        next_free       <= next_free + 1'b1;
      end
      if (fill) begin
        tlb_valid[fifo_ptr] <= 1'b1;
        if (fifo_ptr == tlb_pkg::TLB_IDX_W'(tlb_pkg::TLB_ENTRIES - 1)) begin
          fifo_ptr <= '0;
        end else begin
          fifo_ptr <= fifo_ptr + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && fill) begin
      tlb_page[fifo_ptr]  <= page;
      tlb_frame[fifo_ptr] <= frame;
    end
  end

  // output register
  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata                          <= phys;
      m_tuser[tlb_pkg::USER_HIT]       <= hit;
      m_tuser[tlb_pkg::USER_FAULT]     <= fault;
      m_tuser[tlb_pkg::USER_EXHAUSTED] <= exhausted;
    end
  end

endmodule
`default_nettype wire

/* rtl/tlb_page_table_translator_core.sv */
// Top level of the TLB / page-table address translator.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata: virt_addr[15:0]
//  m_*     | out | m_tvalid/m_tready  | tdata: phys_addr[15:0];
//          |     |                    | tuser: tlb_hit, page_fault, frames_exhausted
//
//  Each address goes through capture plus page-table read, then TLB compare,
//  result and TLB/page-map update. The single-port page-map read sets this split.
//  A new address is taken while the previous result waits in the output register;
//  the lookup cycle holds while that register is full and not being drained.
//  Reset (rst, synchronous) invalidates all TLB and page-map entries at once.
`default_nettype none
module tlb_page_table_translator_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [tlb_pkg::ADDR_W-1:0]        s_tdata,  // [15:0] virt_addr
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [tlb_pkg::ADDR_W-1:0]             m_tdata,  // [15:0] phys_addr
  output logic [tlb_pkg::USER_W-1:0]             m_tuser   // [0] tlb_hit, [1] page_fault,
                                                           // [2] frames_exhausted
);

  tlb_pkg::cmd_t cmd;
  tlb_pkg::sts_t sts;

  tlb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tlb_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

/* rtl/tlb_checker.sv */
// Port-level checker for the translator, bound to the top level.
`default_nettype none
module tlb_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_tvalid,
  input wire logic                        s_tready,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [tlb_pkg::ADDR_W-1:0]  m_tdata,
  input wire logic [tlb_pkg::USER_W-1:0]  m_tuser
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // hit, fault and exhaustion are mutually exclusive
  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tuser))
    else $error("more than one result flag set");

  // no mapping means a zero physical address
  a_exhausted_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[tlb_pkg::USER_EXHAUSTED] |-> m_tdata == '0)
    else $error("nonzero address with frames exhausted");

  // one address in flight: input closes right after an accepted transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction accepted during lookup");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind tlb_page_table_translator_core tlb_checker u_tlb_checker (.*);
`default_nettype wire
